// ===== rtl/tccw_pkg.sv =====
package tccw_pkg;

   localparam int unsigned LINE_STRIDE = 160;

   localparam logic [15:0] OFF_SCREEN = 16'hFFFF;
   localparam logic [7:0]  CODE_CR    = 8'd13;
   localparam logic [7:0]  CODE_LF    = 8'd10;

   localparam logic [6:0] COLUMN_COUNT_RESET   = 7'd80;
   localparam logic [5:0] ROW_COUNT_RESET      = 6'd25;
   localparam logic [2:0] BYTES_PER_CHAR_RESET = 3'd2;
   localparam logic       CURSOR_SHOWN_RESET   = 1'b1;

   localparam int unsigned CSR_INDEX_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH  = 8;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COLUMN_COUNT   = 4'd0,
      CSR_ROW_COUNT      = 4'd1,
      CSR_BYTES_PER_CHAR = 4'd2,
      CSR_CURSOR_SHOWN   = 4'd3
   } csr_index_type;

   typedef enum logic {
      REQ_PUT_CHAR = 1'b0,
      REQ_MOVE     = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic               req_type;
      logic [7:0]         char_code;
      logic signed [15:0] target_x;
      logic signed [15:0] target_y;
   } req_data_type;

   typedef struct packed {
      logic        write_valid;
      logic [15:0] write_offset;
      logic [7:0]  write_code;
      logic        cursor_valid;
      logic [15:0] cursor_offset;
   } rsp_data_type;

   typedef struct packed {
      logic [6:0] column_count;
      logic [5:0] row_count;
      logic [2:0] bytes_per_char;
      logic       cursor_shown;
   } cfg_type;

   typedef struct packed {
      logic [6:0] col;
      logic [5:0] row;
   } cursor_type;

endpackage

// ===== rtl/tccw_csr_regs.sv =====
module tccw_csr_regs
   import tccw_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_COLUMN_COUNT:   cfg_in.column_count   = csr_data[6:0];
            CSR_ROW_COUNT:      cfg_in.row_count      = csr_data[5:0];
            CSR_BYTES_PER_CHAR: cfg_in.bytes_per_char = csr_data[2:0];
            CSR_CURSOR_SHOWN:   cfg_in.cursor_shown   = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.column_count   <= COLUMN_COUNT_RESET;
         cfg_ff.row_count      <= ROW_COUNT_RESET;
         cfg_ff.bytes_per_char <= BYTES_PER_CHAR_RESET;
         cfg_ff.cursor_shown   <= CURSOR_SHOWN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/tccw_step.sv =====
module tccw_step
   import tccw_pkg::*;
(
   input  cfg_type      cfg,
   input  cursor_type   cursor,
   input  req_data_type req,
   output cursor_type   cursor_next,
   output rsp_data_type rsp
);

   function automatic logic [15:0] cell_offset(input logic [6:0] col, input logic [5:0] row,
                                               input logic [2:0] bpc);
      logic [15:0] row_part;
      logic [15:0] col_part;
      row_part = 16'(row) * 16'(LINE_STRIDE);
      col_part = 16'(col) * 16'(bpc);
      return row_part + col_part;
   endfunction

   function automatic logic [6:0] clamp_coord(input logic signed [15:0] v,
                                              input logic [6:0] limit);
      logic [6:0] res;
      if (limit == 7'd0 || v < 0) begin
         res = 7'd0;
      end else if (v >= $signed({9'd0, limit})) begin
         res = limit - 7'd1;
      end else begin
         res = v[6:0];
      end
      return res;
   endfunction

   logic       on_screen;
   logic [6:0] col_inc;
   logic [6:0] row_clamp;

   assign on_screen = (cursor.col < cfg.column_count) && (cursor.row < cfg.row_count);
   assign col_inc   = cursor.col + 7'd1;
   assign row_clamp = clamp_coord(req.target_y, {1'b0, cfg.row_count});

   always_comb begin
      cursor_next       = cursor;
      rsp.write_valid   = 1'b0;
      rsp.write_offset  = 16'd0;
      rsp.write_code    = 8'd0;
      rsp.cursor_valid  = cfg.cursor_shown;
      rsp.cursor_offset = 16'd0;
      if (req.req_type == REQ_MOVE) begin
         cursor_next.col = clamp_coord(req.target_x, cfg.column_count);
         cursor_next.row = row_clamp[5:0];
      end else if (req.char_code == CODE_CR) begin
         cursor_next.col = 7'd0;
      end else if (req.char_code == CODE_LF) begin
         if (cursor.row < cfg.row_count) begin
            cursor_next.row = cursor.row + 6'd1;
         end
      end else if (on_screen) begin
         rsp.write_valid  = 1'b1;
         rsp.write_offset = cell_offset(cursor.col, cursor.row, cfg.bytes_per_char);
         rsp.write_code   = req.char_code;
         if (col_inc >= cfg.column_count) begin
            cursor_next.col = 7'd0;
            cursor_next.row = cursor.row + 6'd1;
         end else begin
            cursor_next.col = col_inc;
         end
      end
      if (cfg.cursor_shown) begin
         rsp.cursor_offset = ((cursor_next.col < cfg.column_count) &&
                              (cursor_next.row < cfg.row_count)) ?
            cell_offset(cursor_next.col, cursor_next.row, cfg.bytes_per_char) : OFF_SCREEN;
      end
   end

endmodule

// ===== rtl/text_console_cursor_writer.sv =====
// Throughput: one request per cycle unless the output stalls; an accepted request enters the
// input register and its result then the result register, and each register holds one item,
// and the cursor register is updated as an item moves into the result register.
// Reset (synchronous, active high): cursor to column 0, row 0; column_count 80,
// row_count 25, bytes_per_char 2, cursor_shown 1; both pipeline registers empty.
module text_console_cursor_writer
   import tccw_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_data_type               req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_data_type               rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type      cfg;
   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_data_type s1_req_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_data_type rsp_data_ff;
   rsp_data_type rsp_calc;
   cursor_type   cursor_ff;
   cursor_type   cursor_in;
   logic         advance;
   logic         s1_fire;
   logic         req_fire;

   tccw_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tccw_step u_step (
      .cfg         (cfg),
      .cursor      (cursor_ff),
      .req         (s1_req_ff),
      .cursor_next (cursor_in),
      .rsp         (rsp_calc)
   );

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !advance);
   assign rsp_valid_in = s1_valid_ff || (rsp_valid_ff && !rsp_ready);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cursor_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            cursor_ff <= cursor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff <= req_data;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_calc;
      end
   end

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_req_ff) && $stable(cursor_ff))
      else $error("stalled input stage lost its transaction or cursor moved");

   a_cursor_only_on_fire: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> $stable(cursor_ff))
      else $error("cursor changed without a transaction");

   a_write_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.write_valid |-> rsp_data.write_offset != OFF_SCREEN)
      else $error("write issued at off-screen offset");

   a_cursor_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.cursor_valid |-> rsp_data.cursor_offset == 16'd0)
      else $error("cursor offset set while cursor update not issued");

endmodule

// ===== verif/text_console_cursor_writer_test.sv =====
`timescale 1ns / 100ps

module text_console_cursor_writer_test
   import tccw_pkg::*;
();

   localparam int NUM_PHASES       = 8;
   localparam int ITEMS_PER_PHASE  = 60;
   localparam int HOLD_OFF_CYCLES  = 120;
   localparam int DRAIN_CYCLES     = 6;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int MAX_REPORTS      = 40;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 4'hF;

   localparam logic [7:0] PHASE_COLS  [NUM_PHASES] =
      '{8'd80, 8'd40, 8'd1, 8'hFF, 8'd80, 8'd0, 8'd3, 8'd80};
   localparam logic [7:0] PHASE_ROWS  [NUM_PHASES] =
      '{8'd25, 8'd20, 8'd1, 8'hFF, 8'd30, 8'd0, 8'd2, 8'd32};
   localparam logic [7:0] PHASE_BPC   [NUM_PHASES] =
      '{8'd2, 8'd4, 8'd2, 8'hFF, 8'd4, 8'd0, 8'd3, 8'd2};
   localparam logic [7:0] PHASE_SHOWN [NUM_PHASES] =
      '{8'd1, 8'd1, 8'd1, 8'hFE, 8'd0, 8'd1, 8'd1, 8'd1};

   class cursor_tracker;
      cfg_type      cfg;
      cursor_type   pos;
      rsp_data_type awaited_rsp[$];
      int           errors;
      int           char_writes;

      function new();
         cfg.column_count   = COLUMN_COUNT_RESET;
         cfg.row_count      = ROW_COUNT_RESET;
         cfg.bytes_per_char = BYTES_PER_CHAR_RESET;
         cfg.cursor_shown   = CURSOR_SHOWN_RESET;
         pos                = '0;
         errors             = 0;
         char_writes        = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                 logic [CSR_DATA_WIDTH-1:0] data);
         case (index)
            CSR_COLUMN_COUNT:   cfg.column_count   = data[6:0];
            CSR_ROW_COUNT:      cfg.row_count      = data[5:0];
            CSR_BYTES_PER_CHAR: cfg.bytes_per_char = data[2:0];
            CSR_CURSOR_SHOWN:   cfg.cursor_shown   = data[0];
            default: ;
         endcase
      endfunction

      function bit on_screen();
         return pos.col < cfg.column_count && pos.row < cfg.row_count;
      endfunction

      function logic [15:0] cell_offset();
         int unsigned raw;
         if (!on_screen()) return OFF_SCREEN;
         raw = pos.row * LINE_STRIDE + pos.col * cfg.bytes_per_char;
         return 16'(raw);
      endfunction

      function void line_feed();
         if (pos.row < cfg.row_count) pos.row = pos.row + 1'b1;
      endfunction

      function int clamp_coord(logic signed [15:0] v, int limit);
         if (limit == 0 || v < 0) return 0;
         if (int'(v) >= limit) return limit - 1;
         return int'(v);
      endfunction

      function void note_request(req_data_type rq);
         rsp_data_type want;
         want = '0;
         if (rq.req_type == REQ_PUT_CHAR) begin
            if (rq.char_code == CODE_CR) begin
               pos.col = '0;
            end else if (rq.char_code == CODE_LF) begin
               line_feed();
            end else if (on_screen()) begin
               want.write_valid  = 1'b1;
               want.write_offset = cell_offset();
               want.write_code   = rq.char_code;
               pos.col = pos.col + 1'b1;
               if (pos.col >= cfg.column_count) begin
                  pos.col = '0;
                  line_feed();
               end
            end
         end else begin
            pos.col = 7'(clamp_coord(rq.target_x, int'(cfg.column_count)));
            pos.row = 6'(clamp_coord(rq.target_y, int'(cfg.row_count)));
         end
         if (cfg.cursor_shown) begin
            want.cursor_valid  = 1'b1;
            want.cursor_offset = cell_offset();
         end
         awaited_rsp.push_back(want);
      endfunction

      task report_mismatch(string what, int got, int want);
         if (errors < MAX_REPORTS)
            $display("ERROR %s: got 0x%0h, expected 0x%0h", what, got, want);
         errors++;
      endtask

      task check_response(rsp_data_type got);
         rsp_data_type want;
         if (awaited_rsp.size() == 0) begin
            report_mismatch("response with no request outstanding",
                            int'(got.cursor_offset), 0);
            return;
         end
         want = awaited_rsp.pop_front();
         if (got.write_valid) char_writes++;
         if (got.write_valid !== want.write_valid)
            report_mismatch("write_valid", int'(got.write_valid), int'(want.write_valid));
         if (got.write_offset !== want.write_offset)
            report_mismatch("write_offset", int'(got.write_offset), int'(want.write_offset));
         if (got.write_code !== want.write_code)
            report_mismatch("write_code", int'(got.write_code), int'(want.write_code));
         if (got.cursor_valid !== want.cursor_valid)
            report_mismatch("cursor_valid", int'(got.cursor_valid), int'(want.cursor_valid));
         if (got.cursor_offset !== want.cursor_offset)
            report_mismatch("cursor_offset", int'(got.cursor_offset),
                            int'(want.cursor_offset));
      endtask

      function int pending();
         return awaited_rsp.size();
      endfunction
   endclass

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   req_data_type               req_data;
   logic                       rsp_valid;
   logic                       rsp_ready;
   rsp_data_type               rsp_data;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   cursor_tracker tracker = new();

   int sender_idle_pct;
   int receiver_stall_pct;
   bit hold_off_request;
   int n_requests;
   int n_responses;
   int n_csr_writes;
   int quiet_cycles;

   text_console_cursor_writer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            tracker.note_request(req_data);
            n_requests++;
         end
         if (rsp_valid && rsp_ready) begin
            tracker.check_response(rsp_data);
            n_responses++;
         end
         if (csr_valid && csr_ready) begin
            tracker.set_register(csr_index, csr_data);
            n_csr_writes++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d responses outstanding",
                     quiet_cycles, tracker.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // output side: random stalls, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            for (int k = 0; k < HOLD_OFF_CYCLES; k++) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   task automatic send_request(input req_data_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_data_type put_request(logic [7:0] code);
      req_data_type rq;
      rq.req_type  = REQ_PUT_CHAR;
      rq.char_code = code;
      rq.target_x  = 16'($urandom);
      rq.target_y  = 16'($urandom);
      return rq;
   endfunction

   function automatic req_data_type move_request(int x, int y);
      req_data_type rq;
      rq.req_type  = REQ_MOVE;
      rq.char_code = 8'($urandom);
      rq.target_x  = 16'(x);
      rq.target_y  = 16'(y);
      return rq;
   endfunction

   function automatic req_data_type random_request();
      int pick;
      int cols;
      int rows;
      cols = int'(tracker.cfg.column_count);
      rows = int'(tracker.cfg.row_count);
      pick = $urandom_range(99);
      if (pick < 12) return put_request(CODE_CR);
      if (pick < 24) return put_request(CODE_LF);
      if (pick < 70) return put_request(8'($urandom));
      if (pick < 92)
         return move_request(int'($urandom_range(cols + 4)) - 2,
                             int'($urandom_range(rows + 4)) - 2);
      return move_request(int'($urandom), int'($urandom));
   endfunction

   // default 80x25 screen
   task automatic run_directed();
      send_request(put_request(8'd72));
      send_request(put_request(8'd0));
      send_request(put_request(8'd255));
      send_request(put_request(CODE_CR));
      send_request(put_request(CODE_LF));
      send_request(put_request(8'd9));
      send_request(move_request(79, 0));
      send_request(put_request(8'd90));     // wraps to next line
      send_request(move_request(79, 24));
      send_request(put_request(8'd81));     // last cell, cursor leaves the screen
      send_request(put_request(8'd88));     // dropped
      send_request(put_request(CODE_LF));   // row saturated
      send_request(put_request(CODE_LF));
      send_request(put_request(CODE_CR));
      send_request(put_request(8'd89));     // still off screen
      send_request(move_request(-32768, -32768));
      send_request(move_request(32767, 32767));
      send_request(move_request(-1, 100));
      send_request(move_request(80, 25));
      send_request(put_request(CODE_LF));   // bottom line feed goes off screen
      send_request(move_request(0, 0));
      send_request(put_request(8'd65));
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data           = '0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_data           = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_request   = 1'b0;
      n_requests         = 0;
      n_responses        = 0;
      n_csr_writes       = 0;
      quiet_cycles       = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
            default: begin sender_idle_pct = 7; receiver_stall_pct = 7; end
         endcase
         write_register(CSR_COLUMN_COUNT, PHASE_COLS[p]);
         write_register(CSR_ROW_COUNT, PHASE_ROWS[p]);
         write_register(CSR_BYTES_PER_CHAR, PHASE_BPC[p]);
         write_register(CSR_CURSOR_SHOWN, PHASE_SHOWN[p]);
         if (p == 3) write_register(CSR_UNUSED_INDEX, 8'hFF);
         if (p == 0) run_directed();
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (p == 0 && i == 10) hold_off_request = 1'b1;
            send_request(random_request());
         end
         drain_responses();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.report_mismatch("responses never delivered", 0, tracker.pending());
      $display("Covered %0d requests, %0d responses (%0d character writes), %0d register writes",
               n_requests, n_responses, tracker.char_writes, n_csr_writes);
      $display("Across %0d screen settings with gaps, stalls and a %0d-cycle output hold-off",
               NUM_PHASES, HOLD_OFF_CYCLES);
      if (tracker.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
